### rtl/gwcc_pkg.sv
package gwcc_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_CONNECTED   = 2'd0,
    ST_INVALID     = 2'd1,
    ST_HEADROOM    = 2'd2,
    ST_UNCONNECTED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIPE,
    S_SCAN,
    S_SCAN_CHK,
    S_ENDS,
    S_ENDS_CHK,
    S_POP,
    S_POP_WAIT,
    S_CUR,
    S_NB,
    S_NB_WAIT,
    S_NB_CHK,
    S_DONE
  } state_t;

  localparam logic [7:0] MIN_CLEAR_RESET = 8'd2;
  localparam logic [7:0] MAX_STEP_RESET  = 8'd1;

  localparam int REG_MIN_CLEAR = 0;
  localparam int REG_MAX_STEP  = 1;

endpackage

### rtl/grid_walk_connectivity_check_core.sv
// grid walk connectivity check. write items (mode 0) load one cell,
// clear items (mode 2) wipe the present bits in one sweep of one
// cell per cycle. a query (mode 1) takes one scan of every cell for
// the presence and headroom checks; an invalid footprint or a headroom
// failure ends it there. otherwise a wipe of the seen store follows,
// then a breadth-first walk: each reached cell is taken off the queue
// (pop, pop wait, cur), then each of its four neighbours is read and
// checked (nb, nb wait, nb chk), all through one read port per memory
// and one shared compare path. after reset a clearing pass over every
// cell runs on the present store before the first item is taken. the
// result word sits in its own register, so a waiting word does not
// hold off the input; a finished query waits in its last state until
// that register is free. the result word is one byte: status in bits
// 1:0, connected in bit 2.
module grid_walk_connectivity_check_core #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream: tdata fields from bit 0: mode, cell_x, cell_y,
  // cell_present, floor_height, ceiling_height, start_x, start_y, end_x,
  // end_y (72 bits used)
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,
  // master stream: tdata fields from bit 0: status, connected
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int QW    = XW + YW;
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = AW + 1;

  // registers
  logic [7:0] min_clear;
  logic [7:0] max_step;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_clear <= gwcc_pkg::MIN_CLEAR_RESET;
      max_step  <= gwcc_pkg::MAX_STEP_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'(gwcc_pkg::REG_MIN_CLEAR) && paddr[1:0] == 2'd0) begin
        min_clear <= pwdata[7:0];
      end else if (paddr[2] == 1'(gwcc_pkg::REG_MAX_STEP) && paddr[1:0] == 2'd0) begin
        max_step <= pwdata[7:0];
      end
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata = {24'd0, min_clear};
    else if (paddr == 3'd4) prdata = {24'd0, max_step};
  end

  // input fields
  logic [1:0]         in_mode;
  logic [5:0]         in_cx, in_cy, in_sx, in_sy, in_ex, in_ey;
  logic               in_pres;
  logic signed [15:0] in_floor;
  logic signed [16:0] in_ceil;
  assign in_mode  = s_tdata[1:0];
  assign in_cx    = s_tdata[7:2];
  assign in_cy    = s_tdata[13:8];
  assign in_pres  = s_tdata[14];
  assign in_floor = s_tdata[30:15];
  assign in_ceil  = s_tdata[47:31];
  assign in_sx    = s_tdata[53:48];
  assign in_sy    = s_tdata[59:54];
  assign in_ex    = s_tdata[65:60];
  assign in_ey    = s_tdata[71:66];

  // memories: present bit, span, seen bit, frontier queue of {y, x}
  logic                valid_mem [CELLS];
  logic signed [15:0]  floor_mem [CELLS];
  logic signed [16:0]  ceil_mem  [CELLS];
  logic                seen_mem  [CELLS];
  logic [QW-1:0]       queue_mem [CELLS];

  gwcc_pkg::state_t state, state_next;

  logic [CW-1:0] cnt;
  logic [AW-1:0] rd_addr;
  logic          rd_valid;
  logic signed [15:0] rd_floor;
  logic signed [16:0] rd_ceil;
  logic          rd_seen;
  logic          vwe, vwd, swe, qwe;
  logic [AW-1:0] vwa, swa, qwa;
  logic [QW-1:0] qwd;
  logic [QW-1:0] q_rd;
  logic [CW-1:0] head, tail;
  logic          any_present;
  logic          ends_pass;
  logic [XW-1:0] sx, cur_x;
  logic [YW-1:0] sy, cur_y;
  logic [AW-1:0] a_idx, b_idx, cur;
  logic signed [15:0] cur_floor;
  logic signed [16:0] cur_ceil;
  logic [1:0]    nb;
  logic [AW-1:0] nb_idx;
  logic          nb_ok;
  logic [1:0]    result;
  logic [1:0]    out_status;
  logic          out_full;
  logic          load_out;
  logic          wipe_init;
  logic          sx_in, sy_in, ex_in, ey_in;

  assign sx_in = {26'd0, in_sx} < 32'(GRID_WIDTH);
  assign sy_in = {26'd0, in_sy} < 32'(GRID_HEIGHT);
  assign ex_in = {26'd0, in_ex} < 32'(GRID_WIDTH);
  assign ey_in = {26'd0, in_ey} < 32'(GRID_HEIGHT);

  function automatic logic [AW-1:0] idx(input logic [XW-1:0] x, input logic [YW-1:0] y);
    idx = AW'(32'(y) * GRID_WIDTH + 32'(x));
  endfunction

  always_ff @(posedge clk) begin
    rd_valid <= valid_mem[rd_addr];
    rd_floor <= floor_mem[rd_addr];
    rd_ceil  <= ceil_mem[rd_addr];
    rd_seen  <= seen_mem[rd_addr];
    q_rd     <= queue_mem[head[AW-1:0]];
    if (vwe) valid_mem[vwa] <= vwd;
    if (swe) seen_mem[swa] <= (state != gwcc_pkg::S_WIPE);
    if (qwe) queue_mem[qwa] <= qwd;
    if (s_tvalid && s_tready && in_mode == gwcc_pkg::MODE_WRITE &&
        32'(in_cx) < GRID_WIDTH && 32'(in_cy) < GRID_HEIGHT) begin
      floor_mem[idx(XW'(in_cx), YW'(in_cy))] <= in_floor;
      ceil_mem[idx(XW'(in_cx), YW'(in_cy))]  <= in_ceil;
    end
  end

  // neighbour step compare, the shared unit
  logic signed [17:0] df, hi_f, lo_c;
  always_comb begin
    df   = 18'(rd_floor) - 18'(cur_floor);
    if (df < 0) df = -df;
    hi_f = (rd_floor > cur_floor) ? 18'(rd_floor) : 18'(cur_floor);
    lo_c = (rd_ceil < cur_ceil) ? 18'(rd_ceil) : 18'(cur_ceil);
    nb_ok = rd_valid && !rd_seen && df <= $signed({10'd0, max_step}) &&
            (lo_c - hi_f) >= $signed({10'd0, min_clear});
  end

  logic nb_in;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  always_comb begin
    nx = cur_x; ny = cur_y; nb_in = 1'b0;
    case (nb)
      2'd0: begin nx = cur_x + 1'b1; nb_in = 32'(cur_x) + 1 < GRID_WIDTH; end
      2'd1: begin nx = cur_x - 1'b1; nb_in = cur_x != '0; end
      2'd2: begin ny = cur_y + 1'b1; nb_in = 32'(cur_y) + 1 < GRID_HEIGHT; end
      default: begin ny = cur_y - 1'b1; nb_in = cur_y != '0; end
    endcase
  end

  always_comb begin
    state_next = state;
    vwe = 1'b0; vwd = 1'b0; vwa = cnt[AW-1:0];
    swe = 1'b0; swa = cnt[AW-1:0]; qwe = 1'b0;
    qwa = tail[AW-1:0]; qwd = {ny, nx};
    load_out = 1'b0;
    rd_addr = cnt[AW-1:0];
    s_tready = (state == gwcc_pkg::S_IDLE);
    unique case (state)
      gwcc_pkg::S_IDLE: begin
        if (s_tvalid && s_tready) begin
          if (in_mode == gwcc_pkg::MODE_WRITE) begin
            vwe = 32'(in_cx) < GRID_WIDTH && 32'(in_cy) < GRID_HEIGHT;
            vwa = idx(XW'(in_cx), YW'(in_cy)); vwd = in_pres;
          end else if (in_mode == gwcc_pkg::MODE_QUERY) begin
            state_next = gwcc_pkg::S_SCAN;
          end else if (in_mode == gwcc_pkg::MODE_CLEAR) begin
            state_next = gwcc_pkg::S_WIPE;
          end
        end
      end
      gwcc_pkg::S_WIPE: begin
        // wipes present bits after reset or clear, seen bits during query
        if (wipe_init) begin vwe = 1'b1; vwd = 1'b0; end
        else swe = 1'b1;
        if (cnt == CW'(CELLS - 1))
          state_next = wipe_init ? gwcc_pkg::S_IDLE : gwcc_pkg::S_ENDS_CHK;
      end
      gwcc_pkg::S_SCAN: state_next = gwcc_pkg::S_SCAN_CHK;
      gwcc_pkg::S_SCAN_CHK: begin
        if (cnt == CW'(CELLS - 1)) state_next = gwcc_pkg::S_ENDS;
        else state_next = gwcc_pkg::S_SCAN;
      end
      gwcc_pkg::S_ENDS: begin
        rd_addr = a_idx;
        // invalid footprint first, then the headroom failure found by the scan
        state_next = (!any_present || min_clear == 8'd0 || !ends_pass ||
                      result == gwcc_pkg::ST_HEADROOM) ?
                     gwcc_pkg::S_DONE : gwcc_pkg::S_WIPE;
      end
      gwcc_pkg::S_ENDS_CHK: begin
        swe = 1'b1; swa = a_idx; qwe = 1'b1;
        qwa = '0; qwd = {sy, sx};
        state_next = gwcc_pkg::S_POP;
      end
      gwcc_pkg::S_POP: begin
        state_next = (head == tail) ? gwcc_pkg::S_DONE : gwcc_pkg::S_POP_WAIT;
      end
      gwcc_pkg::S_POP_WAIT: begin
        rd_addr = idx(q_rd[XW-1:0], q_rd[QW-1:XW]);
        state_next = gwcc_pkg::S_CUR;
      end
      gwcc_pkg::S_CUR: begin
        state_next = (cur == b_idx) ? gwcc_pkg::S_DONE : gwcc_pkg::S_NB;
      end
      gwcc_pkg::S_NB: begin
        rd_addr = idx(nx, ny);
        state_next = nb_in ? gwcc_pkg::S_NB_WAIT : gwcc_pkg::S_NB_CHK;
      end
      gwcc_pkg::S_NB_WAIT: begin
        rd_addr = nb_idx;
        state_next = gwcc_pkg::S_NB_CHK;
      end
      gwcc_pkg::S_NB_CHK: begin
        if (cnt[0] && nb_ok) begin swe = 1'b1; swa = nb_idx; qwe = 1'b1; end
        state_next = (nb == 2'd3) ? gwcc_pkg::S_POP : gwcc_pkg::S_NB;
      end
      gwcc_pkg::S_DONE: begin
        // hand the status over once the result register is free
        load_out = !out_full || m_tready;
        if (load_out) state_next = gwcc_pkg::S_IDLE;
      end
      default: state_next = gwcc_pkg::S_IDLE;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gwcc_pkg::S_WIPE;
      wipe_init <= 1'b1;
      cnt <= '0;
      out_full <= 1'b0;
      head <= '0; tail <= '0;
    end else begin
      state <= state_next;
      if (load_out) out_full <= 1'b1;
      else if (m_tvalid && m_tready) out_full <= 1'b0;
      if (load_out) out_status <= result;
      unique case (state)
        gwcc_pkg::S_IDLE: begin
          cnt <= '0;
          any_present <= 1'b0;
          result <= gwcc_pkg::ST_UNCONNECTED;
          if (s_tvalid && s_tready) begin
            wipe_init <= in_mode == gwcc_pkg::MODE_CLEAR;
            sx <= XW'(in_sx); sy <= YW'(in_sy);
            a_idx <= idx(XW'(in_sx), YW'(in_sy));
            b_idx <= idx(XW'(in_ex), YW'(in_ey));
            ends_pass <= sx_in && sy_in && ex_in && ey_in;
          end
        end
        gwcc_pkg::S_WIPE: cnt <= (cnt == CW'(CELLS - 1)) ? '0 : cnt + 1'b1;
        gwcc_pkg::S_SCAN: ;
        gwcc_pkg::S_SCAN_CHK: begin
          if (rd_valid) any_present <= 1'b1;
          // endpoint presence, sampled while the scan passes them
          if ((cnt[AW-1:0] == a_idx || cnt[AW-1:0] == b_idx) && !rd_valid)
            ends_pass <= 1'b0;
          if (rd_valid && (18'(rd_ceil) - 18'(rd_floor)) < $signed({10'd0, min_clear}))
            result <= gwcc_pkg::ST_HEADROOM;
          cnt <= cnt + 1'b1;
        end
        gwcc_pkg::S_ENDS: begin
          cnt <= '0;
          wipe_init <= 1'b0;
          if (!any_present || min_clear == 8'd0 || !ends_pass)
            result <= gwcc_pkg::ST_INVALID;
        end
        gwcc_pkg::S_ENDS_CHK: begin
          head <= '0; tail <= CW'(1);
          result <= gwcc_pkg::ST_UNCONNECTED;
        end
        gwcc_pkg::S_POP: ;
        gwcc_pkg::S_POP_WAIT: begin
          cur <= idx(q_rd[XW-1:0], q_rd[QW-1:XW]);
          cur_x <= q_rd[XW-1:0];
          cur_y <= q_rd[QW-1:XW];
          head <= head + 1'b1;
        end
        gwcc_pkg::S_CUR: begin
          cur_floor <= rd_floor; cur_ceil <= rd_ceil;
          nb <= 2'd0;
          if (cur == b_idx) result <= gwcc_pkg::ST_CONNECTED;
        end
        gwcc_pkg::S_NB: begin
          nb_idx <= idx(nx, ny);
          cnt <= {{(CW-1){1'b0}}, nb_in};
        end
        gwcc_pkg::S_NB_WAIT: ;
        gwcc_pkg::S_NB_CHK: begin
          if (cnt[0] && nb_ok) tail <= tail + 1'b1;
          nb <= nb + 1'b1;
        end
        gwcc_pkg::S_DONE: ;
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_full;
  assign m_tdata  = {5'd0, out_status == gwcc_pkg::ST_CONNECTED, out_status};

  // checks
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != gwcc_pkg::S_IDLE |-> !s_tready)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped");
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("queue underflow");
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    state == gwcc_pkg::S_DONE && out_full && !m_tready |=> state == gwcc_pkg::S_DONE)
    else $error("result overwritten");

endmodule

### verif/grid_walk_connectivity_check_core_tb.sv
`timescale 1ns / 100ps

module grid_walk_connectivity_check_core_tb;

  localparam int GW = 64;
  localparam int GH = 64;
  localparam int CELLS = GW * GH;
  // no word moving for this long means the block is stuck
  localparam int STALL_LIMIT = 400000;
  // a clear sweep gives no result word, so allow it to finish before config writes
  localparam int SETTLE_CYCLES = 5000;
  // long enough for the input to back up behind a held result
  localparam int HOLD_CYCLES = 60000;

  // mirror of the grid and its answers to queries
  class conn_scoreboard;
    bit present[CELLS];
    int flr[CELLS];
    int ceil_h[CELLS];
    bit seen[CELLS];
    int unsigned min_clear;
    int unsigned max_step;
    gwcc_pkg::status_t want_q[$];
    int errors;

    function new();
      min_clear = gwcc_pkg::MIN_CLEAR_RESET;
      max_step  = gwcc_pkg::MAX_STEP_RESET;
      errors    = 0;
    endfunction

    // status for one query, breadth-first over the 4-neighbours
    function gwcc_pkg::status_t walk(int sx, int sy, int ex, int ey);
      int a, b, cur, cx, cy, nx, ny, n, df, lo, hi, qh, qt;
      bit any;
      int fq[CELLS];
      int dx[4];
      int dy[4];
      dx = '{1, -1, 0, 0};
      dy = '{0, 0, 1, -1};
      any = 0;
      foreach (present[i]) if (present[i]) any = 1;
      if (!any || min_clear < 1) return gwcc_pkg::ST_INVALID;
      a = sy * GW + sx;
      b = ey * GW + ex;
      if (!present[a] || !present[b]) return gwcc_pkg::ST_INVALID;
      foreach (present[i])
        if (present[i] && (ceil_h[i] - flr[i] < int'(min_clear)))
          return gwcc_pkg::ST_HEADROOM;
      foreach (seen[i]) seen[i] = 0;
      qh = 0;
      qt = 0;
      fq[qt] = a;
      qt++;
      seen[a] = 1;
      while (qh < qt) begin
        cur = fq[qh];
        qh++;
        if (cur == b) return gwcc_pkg::ST_CONNECTED;
        cx = cur % GW;
        cy = cur / GW;
        for (int k = 0; k < 4; k++) begin
          nx = cx + dx[k];
          ny = cy + dy[k];
          // no wrap at the grid edge
          if (nx < 0 || ny < 0 || nx >= GW || ny >= GH) continue;
          n = ny * GW + nx;
          if (!present[n] || seen[n]) continue;
          df = flr[n] - flr[cur];
          if (df < 0) df = -df;
          if (df > int'(max_step)) continue;
          lo = (ceil_h[cur] < ceil_h[n]) ? ceil_h[cur] : ceil_h[n];
          hi = (flr[cur] > flr[n]) ? flr[cur] : flr[n];
          if (lo - hi < int'(min_clear)) continue;
          seen[n] = 1;
          fq[qt] = n;
          qt++;
        end
      end
      return gwcc_pkg::ST_UNCONNECTED;
    endfunction

    function void note(logic [71:0] d);
      int idx;
      case (gwcc_pkg::mode_t'(d[1:0]))
        gwcc_pkg::MODE_WRITE: begin
          idx = int'(d[13:8]) * GW + int'(d[7:2]);
          present[idx] = d[14];
          flr[idx]     = int'($signed(d[30:15]));
          ceil_h[idx]  = int'($signed(d[47:31]));
        end
        gwcc_pkg::MODE_QUERY: want_q.insert(want_q.size(),
                                            walk(int'(d[53:48]), int'(d[59:54]),
                                                 int'(d[65:60]), int'(d[71:66])));
        gwcc_pkg::MODE_CLEAR: foreach (present[i]) present[i] = 0;
        default: ;
      endcase
    endfunction

    function void check(logic [7:0] w);
      gwcc_pkg::status_t st;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", w);
        return;
      end
      st = want_q[0];
      want_q.delete(0);
      if (w[1:0] !== st || w[2] !== (st == gwcc_pkg::ST_CONNECTED)) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d connected %0d, got status %0d connected %0d",
                   st, st == gwcc_pkg::ST_CONNECTED, w[1:0], w[2]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  conn_scoreboard sb;
  bit no_idle;   // stretch with no gaps on either side
  bit hold_go;   // asks the receiver for one long hold-off
  int quiet_cycles;

  grid_walk_connectivity_check_core #(
    .GRID_WIDTH (GW),
    .GRID_HEIGHT(GH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // pack one input word, fields from bit 0 upwards
  function automatic logic [71:0] pack_word(gwcc_pkg::mode_t m, int cx, int cy, bit pr,
                                            int f, int c, int sx, int sy, int ex, int ey);
    logic [15:0] f16;
    logic [16:0] c17;
    f16 = f[15:0];
    c17 = c[16:0];
    return {ey[5:0], ex[5:0], sy[5:0], sx[5:0], c17, f16, pr, cy[5:0], cx[5:0], m};
  endfunction

  // offer one word and hold it until taken, sometimes idling first
  task automatic send_word(logic [71:0] d);
    if (!no_idle && $urandom_range(0, 99) < 13) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    sb.note(d);
  endtask

  task automatic put_cell(int cx, int cy, bit pr, int f, int c);
    send_word(pack_word(gwcc_pkg::MODE_WRITE, cx, cy, pr, f, c, 0, 0, 0, 0));
  endtask

  task automatic ask(int sx, int sy, int ex, int ey);
    send_word(pack_word(gwcc_pkg::MODE_QUERY, 0, 0, 0, 0, 0, sx, sy, ex, ey));
  endtask

  task automatic wipe_grid();
    send_word(pack_word(gwcc_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // stop offering and wait for every outstanding result word
  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.want_q.size() != 0);
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup then access, register taken at the access edge
  task automatic reg_write(int idx, logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == gwcc_pkg::REG_MIN_CLEAR) sb.min_clear = v[7:0];
    else sb.max_step = v[7:0];
  endtask

  task automatic set_limits(int mc, int ms);
    settle();
    reg_write(gwcc_pkg::REG_MIN_CLEAR, 32'(mc));
    reg_write(gwcc_pkg::REG_MAX_STEP, 32'(ms));
  endtask

  // mostly short walks of written cells followed by a query, some noise and clears
  task automatic random_burst(int n);
    int cnt, r, len, x, y, base, f, c, px[$], py[$];
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // noise: any field value at all
        send_word(pack_word(gwcc_pkg::mode_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                            $urandom_range(0, 63), $urandom_range(0, 1),
                            $urandom_range(0, 65535) - 32768,
                            $urandom_range(0, 65536) - 32768,
                            $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 63), $urandom_range(0, 63)));
        cnt++;
      end else if (r < 16) begin
        wipe_grid();
        cnt++;
      end else begin
        px.delete();
        py.delete();
        len  = $urandom_range(2, 8);
        x    = $urandom_range(0, 63);
        y    = $urandom_range(0, 63);
        base = $urandom_range(0, 2000) - 1000;
        for (int i = 0; i < len; i++) begin
          f = base + $urandom_range(0, sb.max_step + 2) - 1;
          base = f;
          c = f + sb.min_clear + $urandom_range(0, 8) - 1;
          put_cell(x, y, $urandom_range(0, 9) != 0, f, c);
          px.insert(px.size(), x);
          py.insert(py.size(), y);
          case ($urandom_range(0, 3))
            0: x = (x == 63) ? x : x + 1;
            1: x = (x == 0) ? x : x - 1;
            2: y = (y == 63) ? y : y + 1;
            default: y = (y == 0) ? y : y - 1;
          endcase
        end
        r = $urandom_range(0, len - 1);
        if ($urandom_range(0, 5) == 0) ask(px[0], py[0], $urandom_range(0, 63),
                                            $urandom_range(0, 63));
        else ask(px[0], py[0], px[r], py[r]);
        cnt += len + 1;
      end
    end
  endtask

  // result side: random ready, one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_go) begin
        hold_go = 0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 13);
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check(m_tdata);
    end
  end

  // watchdog on cycles with no word moving on either stream
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("grid_walk_connectivity_check_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    no_idle = 0;
    hold_go = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty grid, unused mode, extremes, edges, headroom
    ask(0, 0, 0, 0);
    send_word(pack_word(gwcc_pkg::MODE_NONE, 63, 63, 1, -1, -1, 63, 63, 63, 63));
    put_cell(0, 0, 1, 0, 10);
    put_cell(1, 0, 1, 1, 10);
    ask(0, 0, 0, 0);
    ask(0, 0, 1, 0);
    ask(0, 0, 5, 5);
    put_cell(63, 63, 1, -32768, 32768);
    put_cell(62, 63, 1, 32767, 32768);
    ask(63, 63, 0, 0);
    put_cell(62, 63, 0, 32767, -32768);
    ask(63, 63, 0, 0);
    put_cell(63, 0, 1, 0, 10);
    ask(0, 0, 63, 0);
    put_cell(2, 0, 1, 3, 10);
    ask(0, 0, 2, 0);
    ask(63, 63, 63, 63);
    wipe_grid();
    ask(0, 0, 0, 0);

    random_burst(30);

    // tight clearance and flat floors
    set_limits(1, 0);
    no_idle = 1;
    random_burst(20);
    no_idle = 0;

    // widest limits, with the result side holding off while input piles up
    set_limits(255, 255);
    hold_go = 1;
    random_burst(25);
    wait_results();
    random_burst(8);

    // zero clearance always reports an invalid footprint
    set_limits(0, 1);
    put_cell(4, 4, 1, 0, 5);
    ask(4, 4, 4, 4);

    set_limits($urandom_range(1, 255), $urandom_range(0, 255));
    random_burst(25);

    settle();
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("grid_walk_connectivity_check_core_tb: PASS");
    end else begin
      $display("grid_walk_connectivity_check_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/gwcc_pkg.sv
rtl/grid_walk_connectivity_check_core.sv
verif/grid_walk_connectivity_check_core_tb.sv
